>>> hw/rtl/scb_pkg.sv
`default_nettype none
package scb_pkg;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int BIN_COUNT_DEF = 648;
  localparam int ITERS = 20;
  localparam int CW = 40;
  localparam int AW = 30;
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic [AW-1:0] DEG90 = AW'(90 * 65536);
  localparam logic [AW-1:0] DEG180 = AW'(180 * 65536);
  localparam logic [AW-1:0] DEG360 = AW'(360 * 65536);

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [AW-1:0] ang_t;

  typedef struct packed {
    logic load;
    logic az_init;
    logic el_init;
    logic rot;
    logic sq_step;
    logic az_save;
    logic bin_calc;
    logic mem_rd;
    logic mem_wr;
    logic out_go;
  } scb_cmd_t;

  function automatic ang_t atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = AW'(2949120);
      5'd1: atan_lut = AW'(1740967);
      5'd2: atan_lut = AW'(919879);
      5'd3: atan_lut = AW'(466945);
      5'd4: atan_lut = AW'(234379);
      5'd5: atan_lut = AW'(117304);
      5'd6: atan_lut = AW'(58666);
      5'd7: atan_lut = AW'(29335);
      5'd8: atan_lut = AW'(14668);
      5'd9: atan_lut = AW'(7334);
      5'd10: atan_lut = AW'(3667);
      5'd11: atan_lut = AW'(1833);
      5'd12: atan_lut = AW'(917);
      5'd13: atan_lut = AW'(458);
      5'd14: atan_lut = AW'(229);
      5'd15: atan_lut = AW'(115);
      5'd16: atan_lut = AW'(57);
      5'd17: atan_lut = AW'(29);
      5'd18: atan_lut = AW'(14);
      5'd19: atan_lut = AW'(7);
      default: atan_lut = '0;
    endcase
  endfunction

  function automatic logic [5:0] ang_bin(input ang_t a, input ang_t maxd, input logic [5:0] cap);
    logic [8:0] d;
    logic [5:0] b;
    ang_t c;
    c = a;
    if (c < 0) c = '0;
    if (c > maxd) c = maxd;
    d = 9'(c >>> 16);
    b = 6'((18'(d) * 18'd205) >> 11);
    if (b != 0) b = b - 6'd1;
    if (b > cap) b = cap;
    return b;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/scb_ctrl.sv
`default_nettype none
module scb_ctrl
  import scb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic in_opcode,
  input  wire logic clr_done,
  output logic busy,
  output logic [4:0] step,
  output scb_cmd_t cmd
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_AZ = 4'd2, S_SQ = 4'd3,
    S_EL = 4'd4, S_ELR = 4'd5, S_BIN = 4'd6, S_RD = 4'd7, S_WR = 4'd8, S_RRD = 4'd9,
    S_OUT = 4'd10, S_AZI = 4'd11;
  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign step = cnt_r;
  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    case (state_r)
      S_CLR: if (clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = (in_opcode == OP_READ) ? S_RRD : S_AZI;
        end
      end
      S_AZI: begin
        cmd.az_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_AZ;
      end
      S_AZ: begin
        cmd.rot = 1'b1;
        cmd.sq_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(ITERS - 1)) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          cmd.az_save = 1'b1;
          state_nxt = S_EL;
        end
      end
      S_EL: begin
        cmd.el_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_ELR;
      end
      S_ELR: begin
        cmd.rot = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(ITERS - 1)) state_nxt = S_BIN;
      end
      S_BIN: begin
        cmd.bin_calc = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        state_nxt = S_OUT;
      end
      S_RRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.out_go = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/scb_dp.sv
`default_nettype none
module scb_dp
  import scb_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int BIN_COUNT = BIN_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire scb_cmd_t cmd,
  input  wire logic [4:0] step,
  input  wire logic in_opcode,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_z,
  input  wire logic [9:0] in_read_bin,
  output logic clr_done,
  output logic out_valid,
  output logic [9:0] out_bin_index,
  output logic signed [SAMPLE_BITS-1:0] out_stored_x,
  output logic signed [SAMPLE_BITS-1:0] out_stored_y,
  output logic signed [SAMPLE_BITS-1:0] out_stored_z,
  output logic [9:0] out_filled_bins,
  output logic [6:0] out_progress_percent
);
  localparam int SB = SAMPLE_BITS;
  localparam int F = 32 - SB;
  localparam int MW = 3 * SB;
  localparam int IW = $clog2(BIN_COUNT);

  logic op_r;
  logic signed [SB-1:0] sx_r, sy_r, sz_r;
  logic [9:0] rb_r;
  cval_t cx_r, cy_r;
  ang_t cz_r, az_r;
  logic az_fix_r, el_fix_r;
  ang_t az_fixv_r, el_fixv_r;
  logic [63:0] sqn_r, sqres_r, sqbit_r;
  logic [9:0] bin_r;
  logic [MW-1:0] mem [BIN_COUNT];
  logic [MW-1:0] rd_r;
  logic [IW-1:0] clr_r;
  logic clr_done_r;
  logic [9:0] cnt_r;

  cval_t dx, dy, xe, ye, ze;
  logic [63:0] sq_t;
  logic [2*SB:0] r2;
  logic was, now_f, rd_ok;
  logic [MW-1:0] newv;
  logic [5:0] ab, eb;
  logic [31:0] pm;

  assign clr_done = clr_done_r;
  assign xe = CW'(sx_r) <<< F;
  assign ye = CW'(sy_r) <<< F;
  assign ze = CW'(sz_r) <<< F;
  assign dx = cy_r >>> step;
  assign dy = cx_r >>> step;
  assign r2 = (2*SB+1)'(sx_r) * (2*SB+1)'(sx_r) + (2*SB+1)'(sy_r) * (2*SB+1)'(sy_r);
  assign sq_t = sqres_r + sqbit_r;
  assign newv = {sx_r, sy_r, sz_r};
  assign was = (rd_r[MW-1 -: SB] != 0) && (rd_r[2*SB-1 -: SB] != 0) && (rd_r[SB-1:0] != 0);
  assign now_f = (sx_r != 0) && (sy_r != 0) && (sz_r != 0);
  assign rd_ok = {22'd0, rb_r} < 32'(BIN_COUNT);
  assign ab = ang_bin(az_r + DEG180, DEG360, 6'd35);
  assign eb = ang_bin((el_fix_r ? el_fixv_r : cz_r) + DEG90, DEG180, 6'd17);
  assign pm = 32'(cnt_r) * 32'd2609210;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      sx_r <= in_sample_x;
      sy_r <= in_sample_y;
      sz_r <= in_sample_z;
      rb_r <= in_read_bin;
    end
    if (cmd.az_init) begin
      az_fix_r <= (sy_r == 0) || (sx_r == 0);
      az_fixv_r <= (sy_r == 0) ? ((sx_r < 0) ? DEG180 : '0) : ((sy_r > 0) ? DEG90 : -DEG90);
      sqn_r <= 64'(r2) << (2 * F);
      sqres_r <= '0;
      sqbit_r <= 64'h4000_0000_0000_0000;
      if (xe < 0) begin
        cx_r <= (ye >= 0) ? ye : -ye;
        cy_r <= (ye >= 0) ? -xe : xe;
        cz_r <= (ye >= 0) ? DEG90 : -DEG90;
      end else begin
        cx_r <= xe;
        cy_r <= ye;
        cz_r <= '0;
      end
    end else if (cmd.el_init) begin
      el_fix_r <= (sz_r == 0) || (sqres_r == 0);
      el_fixv_r <= (sz_r == 0) ? '0 : ((sz_r > 0) ? DEG90 : -DEG90);
      cx_r <= CW'(sqres_r);
      cy_r <= ze;
      cz_r <= '0;
    end else if (cmd.rot) begin
      if (cy_r >= 0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + atan_lut(step);
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - atan_lut(step);
      end
    end
    if (cmd.sq_step && !cmd.az_init) begin
      if (sqn_r >= sq_t) begin
        sqn_r <= sqn_r - sq_t;
        sqres_r <= (sqres_r >> 1) + sqbit_r;
      end else begin
        sqres_r <= sqres_r >> 1;
      end
      sqbit_r <= sqbit_r >> 2;
    end
    if (cmd.az_save) az_r <= az_fix_r ? az_fixv_r : cz_r;
    if (cmd.bin_calc) bin_r <= 10'(eb) * 10'd36 + 10'(ab);
    if (cmd.load && in_opcode == OP_READ) bin_r <= in_read_bin;
  end

  always_ff @(posedge clk) begin
    if (!clr_done_r) mem[clr_r] <= '0;
    else if (cmd.mem_wr) mem[bin_r[IW-1:0]] <= newv;
    if (cmd.mem_rd) rd_r <= mem[bin_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_done_r <= 1'b0;
      cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!clr_done_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == IW'(BIN_COUNT - 1)) clr_done_r <= 1'b1;
      end
      if (cmd.mem_wr) begin
        if (was && !now_f) cnt_r <= cnt_r - 10'd1;
        else if (!was && now_f) cnt_r <= cnt_r + 10'd1;
      end
      out_valid <= cmd.out_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_go) begin
      out_bin_index <= bin_r;
      if (op_r == OP_READ) begin
        out_stored_x <= rd_ok ? rd_r[MW-1 -: SB] : '0;
        out_stored_y <= rd_ok ? rd_r[2*SB-1 -: SB] : '0;
        out_stored_z <= rd_ok ? rd_r[SB-1:0] : '0;
      end else begin
        out_stored_x <= sx_r;
        out_stored_y <= sy_r;
        out_stored_z <= sz_r;
      end
      out_filled_bins <= cnt_r;
      out_progress_percent <= (cnt_r >= 10'd643) ? 7'd100 : 7'(pm >> 24);
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/sphere_coverage_binner.sv
// One request is taken at a time; busy is high until the result strobe.
// The add time is set by two 20-step CORDIC vectorings and a 32-step square root.
// After reset the bin store is cleared one entry per cycle; busy stays high until the clear is done.
// The receiver cannot stall: each result is shown for one cycle under out_valid.
`default_nettype none
module sphere_coverage_binner
  import scb_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int BIN_COUNT = BIN_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic in_opcode,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_z,
  input  wire logic [9:0] in_read_bin,
  output logic out_valid,
  output logic [9:0] out_bin_index,
  output logic signed [SAMPLE_BITS-1:0] out_stored_x,
  output logic signed [SAMPLE_BITS-1:0] out_stored_y,
  output logic signed [SAMPLE_BITS-1:0] out_stored_z,
  output logic [9:0] out_filled_bins,
  output logic [6:0] out_progress_percent
);
  scb_cmd_t cmd;
  logic [4:0] step;
  logic clr_done;

  scb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_opcode(in_opcode),
    .clr_done(clr_done), .busy(busy), .step(step), .cmd(cmd)
  );

  scb_dp #(.SAMPLE_BITS(SAMPLE_BITS), .BIN_COUNT(BIN_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .step(step), .in_opcode(in_opcode),
    .in_sample_x(in_sample_x), .in_sample_y(in_sample_y), .in_sample_z(in_sample_z),
    .in_read_bin(in_read_bin), .clr_done(clr_done), .out_valid(out_valid),
    .out_bin_index(out_bin_index), .out_stored_x(out_stored_x),
    .out_stored_y(out_stored_y), .out_stored_z(out_stored_z),
    .out_filled_bins(out_filled_bins), .out_progress_percent(out_progress_percent)
  );
endmodule
`default_nettype wire

>>> hw/rtl/scb_checker.sv
`default_nettype none
module scb_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic [9:0] out_filled_bins,
  input wire logic [6:0] out_progress_percent
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");
  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");
  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_prog_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_progress_percent <= 7'd100 && out_filled_bins <= 10'd648))
    else $error("progress out of range");
endmodule
bind sphere_coverage_binner scb_checker u_scb_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_filled_bins(out_filled_bins), .out_progress_percent(out_progress_percent)
);
`default_nettype wire

>>> test/sphere_coverage_binner_tb.sv
`default_nettype none
module sphere_coverage_binner_tb;
  import scb_pkg::*;

  localparam int NBINS = BIN_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct {
    logic [9:0] bin;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] sz;
    logic [9:0] filled;
    logic [6:0] prog;
  } bin_result_t;

  typedef struct {
    logic op;
    int x;
    int y;
    int z;
    int rb;
    int exp_bin;
  } bin_row_t;

  logic clk, rst_n, start;
  logic in_opcode;
  logic signed [15:0] in_sample_x, in_sample_y, in_sample_z;
  logic [9:0] in_read_bin;
  wire busy, out_valid;
  wire [9:0] out_bin_index, out_filled_bins;
  wire signed [15:0] out_stored_x, out_stored_y, out_stored_z;
  wire [6:0] out_progress_percent;

  logic signed [15:0] map_x[NBINS];
  logic signed [15:0] map_y[NBINS];
  logic signed [15:0] map_z[NBINS];
  int filled_total;
  bin_result_t bin_results_due[$];
  int errors;
  int idle_cycles;

  sphere_coverage_binner uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_sample_x(in_sample_x), .in_sample_y(in_sample_y),
    .in_sample_z(in_sample_z), .in_read_bin(in_read_bin),
    .out_valid(out_valid), .out_bin_index(out_bin_index),
    .out_stored_x(out_stored_x), .out_stored_y(out_stored_y),
    .out_stored_z(out_stored_z), .out_filled_bins(out_filled_bins),
    .out_progress_percent(out_progress_percent)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint vector_angle(longint vx, longint vy);
    longint angle_tab[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                              29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                              29, 14, 7};
    longint ax, ay, acc, t, dx, dy;
    ax = vx;
    ay = vy;
    acc = 0;
    if (ax < 0) begin
      t = ax;
      if (ay >= 0) begin
        ax = ay; ay = -t; acc = 90 * 65536;
      end else begin
        ax = -ay; ay = t; acc = -90 * 65536;
      end
    end
    for (int i = 0; i < 20; i++) begin
      dx = ay >>> i;
      dy = ax >>> i;
      if (ay >= 0) begin
        ax += dx; ay -= dy; acc += angle_tab[i];
      end else begin
        ax -= dx; ay += dy; acc -= angle_tab[i];
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b, rem;
    res = 0;
    rem = n;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int sector(longint deg, longint maxdeg, int cap);
    longint b;
    if (deg < 0) deg = 0;
    if (deg > maxdeg) deg = maxdeg;
    b = (deg >>> 16) / 10 - 1;
    if (b < 0) b = 0;
    if (b > cap) b = cap;
    return int'(b);
  endfunction

  function automatic int direction_bin(longint x, longint y, longint z);
    longint az, el;
    longint unsigned r2, r;
    if (y == 0) az = (x >= 0) ? 0 : 180 * 65536;
    else if (x == 0) az = (y > 0) ? 90 * 65536 : -90 * 65536;
    else az = vector_angle(x * 65536, y * 65536);
    r2 = longint'(x * x + y * y);
    if (z == 0) el = 0;
    else if (r2 == 0) el = (z > 0) ? 90 * 65536 : -90 * 65536;
    else begin
      r = int_sqrt(r2 << 32);
      el = vector_angle(longint'(r), z * 65536);
    end
    return sector(el + 90 * 65536, 180 * 65536, 17) * 36
         + sector(az + 180 * 65536, 360 * 65536, 35);
  endfunction

  function automatic bin_result_t predict_bin_result(logic op, logic signed [15:0] x,
                                                     logic signed [15:0] y,
                                                     logic signed [15:0] z,
                                                     logic [9:0] rb);
    bin_result_t r;
    int b;
    bit was, now;
    r.sx = '0; r.sy = '0; r.sz = '0;
    if (op == OP_ADD) begin
      b = direction_bin(longint'(x), longint'(y), longint'(z));
      was = map_x[b] != 0 && map_y[b] != 0 && map_z[b] != 0;
      map_x[b] = x; map_y[b] = y; map_z[b] = z;
      now = x != 0 && y != 0 && z != 0;
      if (was && !now) filled_total--;
      else if (!was && now) filled_total++;
      r.sx = x; r.sy = y; r.sz = z;
      r.bin = 10'(b);
    end else begin
      r.bin = rb;
      if (rb < NBINS) begin
        r.sx = map_x[rb]; r.sy = map_y[rb]; r.sz = map_z[rb];
      end
    end
    r.filled = 10'(filled_total);
    r.prog = 7'((filled_total * 100 / 643 > 100) ? 100 : filled_total * 100 / 643);
    return r;
  endfunction

  task automatic send_request(logic op, int x, int y, int z, int rb, int exp_bin,
                              bit allow_idle);
    bin_result_t r;
    if (allow_idle) begin
      while ($urandom_range(99) < 9) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_sample_x = 16'(x);
    in_sample_y = 16'(y);
    in_sample_z = 16'(z);
    in_read_bin = 10'(rb);
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    r = predict_bin_result(op, 16'(x), 16'(y), 16'(z), 10'(rb));
    if (exp_bin >= 0) r.bin = 10'(exp_bin);
    bin_results_due.push_back(r);
  endtask

  function automatic int random_component();
    case ($urandom_range(7))
      0: return 0;
      1: return 32767;
      2: return -32768;
      3: return $urandom_range(1, 100) * (($urandom_range(1) == 1) ? -1 : 1);
      default: return int'(16'($urandom));
    endcase
  endfunction

  always @(posedge clk) begin
    bin_result_t e;
    if (rst_n && out_valid) begin
      if (bin_results_due.size() == 0) begin
        $display("%0t: unexpected result, bin %0d", $time, out_bin_index);
        errors++;
      end else begin
        e = bin_results_due.pop_front();
        if (out_bin_index !== e.bin) begin
          $display("%0t: bin_index expected %0d actual %0d", $time, e.bin, out_bin_index);
          errors++;
        end
        if (out_stored_x !== e.sx) begin
          $display("%0t: stored_x expected %0d actual %0d", $time, e.sx, out_stored_x);
          errors++;
        end
        if (out_stored_y !== e.sy) begin
          $display("%0t: stored_y expected %0d actual %0d", $time, e.sy, out_stored_y);
          errors++;
        end
        if (out_stored_z !== e.sz) begin
          $display("%0t: stored_z expected %0d actual %0d", $time, e.sz, out_stored_z);
          errors++;
        end
        if (out_filled_bins !== e.filled) begin
          $display("%0t: filled_bins expected %0d actual %0d", $time, e.filled,
                   out_filled_bins);
          errors++;
        end
        if (out_progress_percent !== e.prog) begin
          $display("%0t: progress_percent expected %0d actual %0d", $time, e.prog,
                   out_progress_percent);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    bin_row_t rows[] = '{
      '{OP_READ, 0, 0, 0, 0, 0},
      '{OP_ADD, 0, 0, 0, 0, 305},
      '{OP_READ, 0, 0, 0, 305, 305},
      '{OP_ADD, 32767, 0, 0, 1023, 305},
      '{OP_ADD, -32768, 0, 0, 0, 323},
      '{OP_ADD, 0, 0, 32767, 0, 629},
      '{OP_ADD, 0, 0, -32768, 0, 17},
      '{OP_ADD, 0, 32767, 0, 0, 314},
      '{OP_ADD, 0, -32768, 0, 0, 296},
      '{OP_ADD, 32767, 32767, 32767, 0, -1},
      '{OP_ADD, -32768, -32768, -32768, 0, -1},
      '{OP_ADD, 32767, -32768, 1, 0, -1},
      '{OP_ADD, 1, -1, 1, 0, -1},
      '{OP_ADD, -1, 1, -1, 0, -1},
      '{OP_ADD, -100, 37, 5, 0, -1},
      '{OP_ADD, 1, -1, 0, 0, -1},
      '{OP_READ, 0, 0, 0, 1023, 1023},
      '{OP_READ, 0, 0, 0, 648, 648},
      '{OP_READ, 0, 0, 0, 647, 647},
      '{OP_READ, -1, -1, -1, 323, 323},
      '{OP_READ, 0, 0, 0, 629, 629}
    };
    int rb;
    errors = 0;
    idle_cycles = 0;
    filled_total = 0;
    for (int i = 0; i < NBINS; i++) begin
      map_x[i] = '0; map_y[i] = '0; map_z[i] = '0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_ADD;
    in_sample_x = '0;
    in_sample_y = '0;
    in_sample_z = '0;
    in_read_bin = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i])
      send_request(rows[i].op, rows[i].x, rows[i].y, rows[i].z, rows[i].rb,
                   rows[i].exp_bin, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        @(negedge clk);
        start = 1'b0;
        while (bin_results_due.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 80) begin
        send_request(OP_ADD, random_component(), random_component(), random_component(),
                     $urandom_range(1023), -1, n < 400 || n >= 700);
      end else begin
        rb = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(NBINS - 1);
        send_request(OP_READ, int'(16'($urandom)), int'(16'($urandom)),
                     int'(16'($urandom)), rb, -1, n < 400 || n >= 700);
      end
    end
    @(negedge clk);
    start = 1'b0;
    while (bin_results_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/scb_pkg.sv
hw/rtl/scb_ctrl.sv
hw/rtl/scb_dp.sv
hw/rtl/sphere_coverage_binner.sv
hw/rtl/scb_checker.sv
test/sphere_coverage_binner_tb.sv
